// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, checked outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

// ===== rtl/cbm_pkg.sv =====
package cbm_pkg;

	// Internal RAM geometry
	localparam int RAM_BYTES = 32768;
	localparam int RAM_AW = $clog2(RAM_BYTES);
	localparam int RAM_CLR_W = RAM_AW + 1;

	// ROM banking
	localparam int MAX_ROM_BANKS = 512;
	localparam int BANK_W = 9;
	localparam int BANK_CNT_W = 10;
	localparam int DIV_CNT_W = 4;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(BANK_W - 1);
	localparam logic [BANK_CNT_W-1:0] BANK_CNT_MAX = BANK_CNT_W'(MAX_ROM_BANKS);
	localparam logic [BANK_CNT_W-1:0] BANK_CNT_RST = BANK_CNT_W'(2);
	localparam logic [BANK_W-1:0] BANK_ONE = BANK_W'(1);

	// Configuration registers
	localparam int RAM_SIZE_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = 2'd1;
	localparam logic [RAM_SIZE_W-1:0] RAM_SIZE_BANKED = 16'd32768;
	localparam logic [RAM_SIZE_W-1:0] RAM_SIZE_WINDOW = 16'd8192;

	// Bus address decode
	localparam logic [2:0] RAM_WINDOW_TOP = 3'b101;
	localparam logic [3:0] BANK_LO_SEL = 4'h2;
	localparam logic [3:0] BANK_HI_SEL = 4'h3;
	localparam logic [2:0] RAM_BANK_SEL = 3'b010;
	localparam logic [7:0] OPEN_BUS = 8'hFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RESP
	} cbm_state_t;

endpackage

// ===== rtl/cartridge_bank_mapper_core.sv =====
// Flow: an accepted transaction is captured, passes the ST_RESP state and is loaded into
// the output register; ROM bank-select writes first run through the ST_DIV state.
// Throughput: one transaction at a time; the bank modulo is a restoring divider
// that retires one quotient bit per cycle (9 steps); the RAM read data is registered.
// Reset: registers return to their defaults and a clearing pass writes zero to
// all 32768 RAM bytes, one per cycle; no transaction is taken until it ends.
`include "assert_macros.svh"

module cartridge_bank_mapper_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbm_pkg::RAM_SIZE_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [15:0]                       bus_address,
	input  logic [7:0]                        write_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        read_byte,
	output logic                              rom_fetch,
	output logic [22:0]                       rom_offset,
	output logic                              handled
);
	import cbm_pkg::*;

	// Configuration and bank state
	logic [BANK_CNT_W-1:0] rom_bank_count_q;
	logic [RAM_SIZE_W-1:0] ram_size_q;
	logic [7:0]            bank_low_q;
	logic                  bank_high_q;
	logic [BANK_W-1:0]     rom_bank_q;
	logic [1:0]            ram_bank_q;

	// Control
	cbm_state_t            state_q, state_d;
	logic [RAM_CLR_W-1:0]  clr_cnt_q;
	logic                  clearing;
	logic                  in_acc;
	logic                  resp_load;
	logic                  div_last;

	// Captured transaction
	logic                  wr_q;
	logic [15:0]           addr_q;
	logic                  mapped_q;

	// Divider
	logic [BANK_W-1:0]     raw_q;
	logic [BANK_W-1:0]     rem_q;
	logic [BANK_CNT_W-1:0] div_cnt_q;
	logic [DIV_CNT_W-1:0]  step_q;
	logic [BANK_CNT_W-1:0] trial;
	logic [BANK_W-1:0]     rem_next;

	// Memory port
	logic [7:0]            ram_mem [RAM_BYTES];
	logic                  mem_we;
	logic [RAM_AW-1:0]     mem_addr;
	logic [7:0]            mem_wdata;
	logic [7:0]            mem_rdata_q;

	// Decode of the incoming transaction
	logic                  in_low, in_ramwin, in_mapped, in_bank_wr;
	logic [BANK_W-1:0]     new_raw;
	logic [BANK_CNT_W-1:0] cnt_clamped;

	// Output register
	logic                  out_valid_q;
	logic [7:0]            read_byte_q;
	logic                  rom_fetch_q;
	logic [22:0]           rom_offset_q;
	logic                  handled_q;
	logic                  low_r, ramwin_r;

	assign clearing = ~clr_cnt_q[RAM_AW];
	assign in_acc   = in_valid & ~in_stall;

	// Address decode; a RAM page is mapped below min(size, 8 KiB)
	always_comb begin
		in_low    = ~bus_address[15];
		in_ramwin = (bus_address[15:13] == RAM_WINDOW_TOP);
		in_mapped = (ram_size_q >= RAM_SIZE_WINDOW) ||
		            ({3'b000, bus_address[12:8]} < ram_size_q[15:8]);
		in_bank_wr = action & in_low &
		             ((bus_address[15:12] == BANK_LO_SEL) ||
		              (bus_address[15:12] == BANK_HI_SEL));
		new_raw = {bank_high_q, bank_low_q};
		if (bus_address[15:12] == BANK_LO_SEL)
			new_raw[7:0] = write_byte;
		else
			new_raw[8] = write_byte[0];
		cnt_clamped = (rom_bank_count_q > BANK_CNT_MAX) ? BANK_CNT_MAX : rom_bank_count_q;
	end

	// One restoring step; a zero modulus leaves the bank unreduced
	always_comb begin
		trial    = {rem_q, raw_q[BANK_W-1]};
		rem_next = (trial >= div_cnt_q) ? BANK_W'(trial - div_cnt_q) : trial[BANK_W-1:0];
		div_last = (state_q == ST_DIV) && (step_q == DIV_LAST);
	end

	// Memory port: clearing pass, else the transaction's entry
	always_comb begin
		mem_we    = clearing | (in_acc & action & in_ramwin & in_mapped);
		mem_addr  = clearing ? clr_cnt_q[RAM_AW-1:0]
		                     : RAM_AW'({ram_bank_q, bus_address[12:0]});
		mem_wdata = clearing ? 8'h00 : write_byte;
	end

	// Read data is taken on acceptance and held until the result is loaded
	always_ff @(posedge clk) begin
		if (mem_we)
			ram_mem[mem_addr] <= mem_wdata;
		if (in_acc)
			mem_rdata_q <= ram_mem[mem_addr];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc)
					state_d = in_bank_wr ? ST_DIV : ST_RESP;
			end
			ST_DIV: begin
				if (div_last)
					state_d = ST_RESP;
			end
			ST_RESP: begin
				if (resp_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_stall  = clearing | (state_q != ST_IDLE);
		resp_load = (state_q == ST_RESP) & (~out_valid_q | ~out_stall);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			clr_cnt_q        <= '0;
			rom_bank_count_q <= BANK_CNT_RST;
			ram_size_q       <= '0;
			bank_low_q       <= 8'h01;
			bank_high_q      <= 1'b0;
			rom_bank_q       <= BANK_ONE;
			ram_bank_q       <= '0;
			out_valid_q      <= 1'b0;
			step_q           <= '0;
		end else begin
			state_q <= state_d;
			if (clearing)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cfg_we) begin
				if (cfg_index == CFG_ROM_BANK_COUNT)
					rom_bank_count_q <= cfg_data[BANK_CNT_W-1:0];
				else if (cfg_index == CFG_RAM_SIZE)
					ram_size_q <= cfg_data;
			end
			if (in_acc && in_bank_wr) begin
				bank_low_q  <= new_raw[7:0];
				bank_high_q <= new_raw[8];
			end
			if (in_acc && action && in_low && (bus_address[15:13] == RAM_BANK_SEL) &&
			    (ram_size_q == RAM_SIZE_BANKED))
				ram_bank_q <= write_byte[1:0];
			if (in_acc)
				step_q <= '0;
			else if (state_q == ST_DIV)
				step_q <= step_q + 1'b1;
			if (div_last)
				rom_bank_q <= (rem_next == '0) ? BANK_ONE : rem_next;
			if (resp_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Transaction and divider datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			wr_q      <= action;
			addr_q    <= bus_address;
			mapped_q  <= in_mapped;
			raw_q     <= new_raw;
			rem_q     <= '0;
			div_cnt_q <= cnt_clamped;
		end else if (state_q == ST_DIV) begin
			raw_q <= {raw_q[BANK_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	// Result formation
	always_comb begin
		low_r    = ~addr_q[15];
		ramwin_r = (addr_q[15:13] == RAM_WINDOW_TOP);
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			handled_q   <= low_r | ramwin_r;
			rom_fetch_q <= ~wr_q & low_r;
			if (!wr_q && low_r)
				rom_offset_q <= addr_q[14] ? {rom_bank_q, addr_q[13:0]}
				                           : {7'b0, addr_q};
			else
				rom_offset_q <= '0;
			if (!wr_q && ramwin_r)
				read_byte_q <= mapped_q ? mem_rdata_q : OPEN_BUS;
			else
				read_byte_q <= 8'h00;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_byte  = read_byte_q;
	assign rom_fetch  = rom_fetch_q;
	assign rom_offset = rom_offset_q;
	assign handled    = handled_q;

	`ASSERT_ALWAYS(a_no_accept_clear, !(clearing && in_acc), "transaction taken during RAM clear")
	`ASSERT_ALWAYS(a_bank_nonzero, rom_bank_q != '0, "active ROM bank is zero")
	`ASSERT_CLK(a_div_bound, (state_q == ST_DIV) |-> (step_q <= DIV_LAST), "divider overran")
	`ASSERT_CLK(a_resp_src, $rose(out_valid_q) |-> $past(state_q == ST_RESP), "result without response state")

endmodule

// ===== verif/cbm_access_checker.sv =====
`timescale 1ns / 100ps

module cbm_access_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbm_pkg::RAM_SIZE_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           action,
	input  logic [15:0]                    bus_address,
	input  logic [7:0]                     write_byte,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [7:0]                     read_byte,
	input  logic                           rom_fetch,
	input  logic [22:0]                    rom_offset,
	input  logic                           handled,
	output int                             errors,
	output int                             pending,
	output int                             checked
);
	import cbm_pkg::*;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic        rom_fetch;
		logic [22:0] rom_offset;
		logic        handled;
	} decode_t;

	// Mirror of the mapper registers and its RAM
	logic [BANK_CNT_W-1:0] bank_count;
	logic [RAM_SIZE_W-1:0] ram_size;
	logic [7:0]            sel_low;
	logic                  sel_high;
	logic [BANK_W-1:0]     rom_bank;
	logic [1:0]            ram_bank;
	logic [7:0]            ram_mirror [RAM_BYTES];
	decode_t               decodes_due [$];

	// Bank number from the select bits: clamp the modulus, reduce, never bank 0
	function automatic logic [BANK_W-1:0] reduce_bank(input logic [BANK_CNT_W-1:0] cnt,
			input logic hi, input logic [7:0] lo);
		int raw;
		int modulus;
		raw = int'({hi, lo});
		modulus = (cnt > BANK_CNT_MAX) ? MAX_ROM_BANKS : int'(cnt);
		if (modulus != 0) begin
			raw = raw % modulus;
		end
		if (raw == 0) begin
			raw = 1;
		end
		return BANK_W'(raw);
	endfunction

	// Expected outcome of one bus access; updates the mirror as a side effect
	task automatic decode_bus_access(input logic wr, input logic [15:0] addr,
			input logic [7:0] data, output decode_t res);
		logic [7:0]            page;
		logic [RAM_SIZE_W-1:0] span;
		logic                  mapped;
		logic [RAM_AW-1:0]     idx;
		res = '0;
		page = addr[15:8];
		idx = {ram_bank, addr[12:0]};
		if (addr < 16'h8000) begin
			res.handled = 1'b1;
			if (!wr) begin
				res.rom_fetch = 1'b1;
				res.rom_offset = addr[14] ? {rom_bank, addr[13:0]} : 23'(addr);
			end else if (addr >= 16'h2000 && addr < 16'h3000) begin
				sel_low = data;
				rom_bank = reduce_bank(bank_count, sel_high, sel_low);
			end else if (addr >= 16'h3000 && addr < 16'h4000) begin
				sel_high = data[0];
				rom_bank = reduce_bank(bank_count, sel_high, sel_low);
			end else if (addr >= 16'h4000 && addr < 16'h6000) begin
				if (ram_size == RAM_SIZE_BANKED) begin
					ram_bank = data[1:0];
				end
			end
		end else if (page >= 8'hA0 && page <= 8'hBF) begin
			// only pages below min(size, 8 KiB) are backed by RAM
			span = (ram_size > RAM_SIZE_WINDOW) ? RAM_SIZE_WINDOW : ram_size;
			mapped = (16'(page - 8'hA0)) < (span >> 8);
			res.handled = 1'b1;
			if (wr) begin
				if (mapped) begin
					ram_mirror[idx] = data;
				end
			end else begin
				res.read_byte = mapped ? ram_mirror[idx] : OPEN_BUS;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
			errors++;
		end
	endtask

	// Watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		decode_t want;
		if (!arst_n) begin
			bank_count = BANK_CNT_RST;
			ram_size = '0;
			sel_low = 8'h01;
			sel_high = 1'b0;
			rom_bank = BANK_ONE;
			ram_bank = '0;
			for (int i = 0; i < RAM_BYTES; i++) begin
				ram_mirror[i] = 8'h00;
			end
			decodes_due.delete();
			errors = 0;
			pending = 0;
			checked = 0;
		end else begin
			// result side first: it always belongs to an older transaction
			if (out_valid && !out_stall) begin
				if (decodes_due.size() == 0) begin
					$error("result with no transaction outstanding");
					errors++;
				end else begin
					want = decodes_due.pop_front();
					checked++;
					check_field("read_byte", 32'(want.read_byte), 32'(read_byte));
					check_field("rom_fetch", 32'(want.rom_fetch), 32'(rom_fetch));
					check_field("rom_offset", 32'(want.rom_offset), 32'(rom_offset));
					check_field("handled", 32'(want.handled), 32'(handled));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROM_BANK_COUNT: bank_count = cfg_data[BANK_CNT_W-1:0];
					CFG_RAM_SIZE:       ram_size = cfg_data;
					default:            ;
				endcase
			end
			if (in_valid && !in_stall) begin
				decode_bus_access(action, bus_address, write_byte, want);
				decodes_due.push_back(want);
			end
			pending = decodes_due.size();
		end
	end

endmodule

// ===== verif/tb_cartridge_bank_mapper_core.sv =====
`timescale 1ns / 100ps

module tb_cartridge_bank_mapper_core;
	import cbm_pkg::*;

	// Register indexes past the last real register; the block ignores them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS = 200;

	// Register settings per random phase; the last one runs without idling
	localparam logic [15:0] COUNT_SET [RANDOM_PHASES] =
		'{16'd3, 16'd512, 16'd1, 16'hFC64, 16'd513, 16'd0, 16'd1023};
	localparam logic [15:0] SIZE_SET [RANDOM_PHASES] =
		'{16'd256, 16'd32768, 16'd8192, 16'd32767, 16'd65535, 16'd4352, 16'd32768};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [RAM_SIZE_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  action;
	logic [15:0]           bus_address;
	logic [7:0]            write_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            read_byte;
	logic                  rom_fetch;
	logic [22:0]           rom_offset;
	logic                  handled;

	int n_errors;
	int n_pending;
	int n_checked;
	int n_sent = 0;
	int n_reg_writes = 0;
	bit steady = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	cartridge_bank_mapper_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.bus_address (bus_address),
		.write_byte  (write_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_byte   (read_byte),
		.rom_fetch   (rom_fetch),
		.rom_offset  (rom_offset),
		.handled     (handled)
	);

	cbm_access_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.bus_address (bus_address),
		.write_byte  (write_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_byte   (read_byte),
		.rom_fetch   (rom_fetch),
		.rom_offset  (rom_offset),
		.handled     (handled),
		.errors      (n_errors),
		.pending     (n_pending),
		.checked     (n_checked)
	);

	// Result-side backpressure in bursts of random length
	initial out_stall = 1'b0;
	always begin
		@(negedge clk);
		if (!steady && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 16)) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	// One bus transaction, with an occasional idle burst ahead of it
	task automatic put_access(input logic wr, input logic [15:0] addr, input logic [7:0] data);
		if (!steady && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		action <= wr;
		bus_address <= addr;
		write_byte <= data;
		do @(posedge clk); while (in_stall);
		n_sent++;
	endtask

	// Stop sending and let every outstanding result come back
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (n_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_reg_writes++;
	endtask

	// Bank selects, banked reads and RAM traffic, with some random noise
	task automatic random_access();
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  data;
		int          pick;
		pick = $urandom_range(0, 99);
		wr = 1'b1;
		data = 8'($urandom_range(0, 255));
		addr = 16'($urandom_range(0, 16'hFFFF));
		if (pick < 12) begin
			addr = 16'(16'h2000 | $urandom_range(0, 16'h0FFF));
			if ($urandom_range(0, 7) == 0) begin
				data = 8'h00;
			end
		end else if (pick < 18) begin
			addr = 16'(16'h3000 | $urandom_range(0, 16'h0FFF));
		end else if (pick < 24) begin
			addr = 16'(16'h4000 | $urandom_range(0, 16'h1FFF));
		end else if (pick < 48) begin
			wr = 1'b0;
			addr = ($urandom_range(0, 9) < 7) ? 16'(16'h4000 | $urandom_range(0, 16'h3FFF))
				: 16'($urandom_range(0, 16'h3FFF));
		end else if (pick < 78) begin
			wr = 1'($urandom_range(0, 1));
			// a small hot set so reads often land on bytes just written
			addr = ($urandom_range(0, 1) == 0) ? 16'(16'hA000 | $urandom_range(0, 16'h1FFF))
				: 16'(16'hA000 + ($urandom_range(0, 31) << 8) + $urandom_range(0, 3));
		end else begin
			wr = 1'($urandom_range(0, 1));
		end
		put_access(wr, addr, data);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ROM_BANK_COUNT;
		cfg_data = '0;
		in_valid = 1'b0;
		action = 1'b0;
		bus_address = '0;
		write_byte = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: two banks, no RAM
		put_access(1'b0, 16'h0000, 8'h00);
		put_access(1'b0, 16'h3FFF, 8'hFF);
		put_access(1'b0, 16'h4000, 8'h00);
		put_access(1'b0, 16'h7FFF, 8'h00);
		put_access(1'b0, 16'hA000, 8'h00);  // no RAM: open bus
		put_access(1'b1, 16'hA000, 8'h5A);
		put_access(1'b0, 16'hBFFF, 8'h00);
		put_access(1'b0, 16'h8000, 8'h00);  // outside the cartridge
		put_access(1'b1, 16'h9FFF, 8'hFF);
		put_access(1'b0, 16'hC000, 8'h00);
		put_access(1'b0, 16'hFFFF, 8'hFF);
		put_access(1'b1, 16'h2000, 8'h00);  // bank 0 turns into bank 1
		put_access(1'b0, 16'h4000, 8'h00);
		put_access(1'b1, 16'h3FFF, 8'hFF);  // 256 mod 2 is 0, again bank 1
		put_access(1'b1, 16'h4000, 8'h03);  // RAM bank select without banked RAM
		put_access(1'b1, 16'h0000, 8'hFF);
		put_access(1'b1, 16'h7FFF, 8'hFF);

		// Zero bank count leaves the bank unreduced; full banked RAM
		quiesce();
		set_reg(CFG_ROM_BANK_COUNT, 16'd0);
		set_reg(CFG_RAM_SIZE, 16'd32768);
		put_access(1'b1, 16'h2FFF, 8'hFF);
		put_access(1'b0, 16'h7FFF, 8'h00);  // top of the ROM offset range
		put_access(1'b1, 16'h5FFF, 8'h03);
		put_access(1'b1, 16'hBFFF, 8'hA5);
		put_access(1'b0, 16'hBFFF, 8'h00);
		put_access(1'b1, 16'h4000, 8'h00);
		put_access(1'b0, 16'hBFFF, 8'h00);

		// Count above the maximum is clamped
		quiesce();
		set_reg(CFG_ROM_BANK_COUNT, 16'd1023);
		set_reg(CFG_RAM_SIZE, 16'd8192);
		put_access(1'b1, 16'h3000, 8'hFE);
		put_access(1'b0, 16'h6ABC, 8'h00);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			quiesce();
			if (p == RANDOM_PHASES - 1) begin
				steady = 1'b1;
			end
			if (p == 3) begin
				set_reg(CFG_SPARE_A, 16'hFFFF);
				set_reg(CFG_SPARE_B, 16'h0000);
			end
			if (p % 2 == 0) begin
				set_reg(CFG_ROM_BANK_COUNT, COUNT_SET[p]);
				set_reg(CFG_RAM_SIZE, SIZE_SET[p]);
			end else begin
				set_reg(CFG_RAM_SIZE, SIZE_SET[p]);
				set_reg(CFG_ROM_BANK_COUNT, COUNT_SET[p]);
			end
			repeat (PHASE_ITEMS) random_access();
		end

		quiesce();
		$display("Sent %0d bus transactions and %0d register writes; %0d results compared.",
			n_sent, n_reg_writes, n_checked);
		$display("Bank counts ran from 0 through 1023, RAM sizes from none to 64 KiB.");
		if (n_errors == 0 && n_pending == 0) begin
			$display("cartridge_bank_mapper_core: match");
		end else begin
			$display("cartridge_bank_mapper_core: mismatch");
		end
		$finish;
	end

	// Hard stop covers the RAM clearing pass and the whole stimulus many times over
	initial begin
		#4_000_000;
		$display("cartridge_bank_mapper_core: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cartridge_bank_mapper_core.sv
verif/cbm_access_checker.sv
verif/tb_cartridge_bank_mapper_core.sv
